// ----- rtl/core/ed_pkg.sv -----
`timescale 1ns / 1ps

package ed_pkg;

    // Transaction field widths
    localparam int KIND_W = 2;
    localparam int SYM_W  = 8;
    localparam int DIST_W = 7;

    // Transaction kinds
    localparam logic [KIND_W-1:0] KIND_TARGET = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SOURCE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

    // Microprogram geometry
    localparam int UPC_W = 4;

    // Jump conditions
    localparam logic [3:0] C_ALWAYS   = 4'd0;
    localparam logic [3:0] C_NO_START = 4'd1;
    localparam logic [3:0] C_KIND0    = 4'd2;
    localparam logic [3:0] C_KIND1    = 4'd3;
    localparam logic [3:0] C_KIND2    = 4'd4;
    localparam logic [3:0] C_TFULL    = 4'd5;
    localparam logic [3:0] C_SFULL    = 4'd6;
    localparam logic [3:0] C_TZERO    = 4'd7;
    localparam logic [3:0] C_J_MORE   = 4'd8;

    // Read address selects
    localparam logic [1:0] RD_J      = 2'd0;
    localparam logic [1:0] RD_J_NEXT = 2'd1;
    localparam logic [1:0] RD_TLEN   = 2'd2;

    // Step addresses
    localparam logic [UPC_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [UPC_W-1:0] ST_DISP0 = 4'd1;
    localparam logic [UPC_W-1:0] ST_DISP1 = 4'd2;
    localparam logic [UPC_W-1:0] ST_DISP2 = 4'd3;
    localparam logic [UPC_W-1:0] ST_DROP  = 4'd4;
    localparam logic [UPC_W-1:0] ST_OVF   = 4'd5;
    localparam logic [UPC_W-1:0] ST_T0    = 4'd6;
    localparam logic [UPC_W-1:0] ST_T1    = 4'd7;
    localparam logic [UPC_W-1:0] ST_S0    = 4'd8;
    localparam logic [UPC_W-1:0] ST_S1    = 4'd9;
    localparam logic [UPC_W-1:0] ST_S2    = 4'd10;
    localparam logic [UPC_W-1:0] ST_CELL  = 4'd11;
    localparam logic [UPC_W-1:0] ST_SDONE = 4'd12;
    localparam logic [UPC_W-1:0] ST_E0    = 4'd13;
    localparam logic [UPC_W-1:0] ST_E1    = 4'd14;
    localparam logic [UPC_W-1:0] ST_SPARE = 4'd15;

    typedef struct packed {
        logic [3:0]       cond;
        logic [UPC_W-1:0] target;
        logic [1:0]       rd_sel;
        logic             ld_tgt;
        logic             src_init;
        logic             cell_en;
        logic             set_ovf;
        logic             emit;
    } ctrl_t;

    typedef struct packed {
        logic kind0;
        logic kind1;
        logic kind2;
        logic tfull;
        logic sfull;
        logic tzero;
        logic jmore;
    } status_t;

    // Control store: one word per step; a false condition falls through to the next step
    function automatic ctrl_t ed_rom(input logic [UPC_W-1:0] addr);
        ctrl_t w;
        w = '0;
        unique case (addr)
            ST_IDLE:  begin w.cond = C_NO_START; w.target = ST_IDLE;  end
            ST_DISP0: begin w.cond = C_KIND0;    w.target = ST_T0;    end
            ST_DISP1: begin w.cond = C_KIND1;    w.target = ST_S0;    end
            ST_DISP2: begin w.cond = C_KIND2;    w.target = ST_E0;    end
            ST_DROP:  begin w.cond = C_ALWAYS;   w.target = ST_IDLE;  end
            ST_OVF:
            begin
                w.cond    = C_ALWAYS;
                w.target  = ST_IDLE;
                w.set_ovf = 1'b1;
            end
            ST_T0:    begin w.cond = C_TFULL;    w.target = ST_OVF;   end
            ST_T1:
            begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
                w.ld_tgt = 1'b1;
            end
            ST_S0:    begin w.cond = C_SFULL;    w.target = ST_OVF;   end
            ST_S1:
            begin
                w.cond     = C_TZERO;
                w.target   = ST_IDLE;
                w.src_init = 1'b1;
            end
            ST_S2:
            begin
                w.cond   = C_ALWAYS;
                w.target = ST_CELL;
                w.rd_sel = RD_J;
            end
            ST_CELL:
            begin
                w.cond    = C_J_MORE;
                w.target  = ST_CELL;
                w.rd_sel  = RD_J_NEXT;
                w.cell_en = 1'b1;
            end
            ST_SDONE: begin w.cond = C_ALWAYS;   w.target = ST_IDLE;  end
            ST_E0:
            begin
                w.cond   = C_ALWAYS;
                w.target = ST_E1;
                w.rd_sel = RD_TLEN;
            end
            ST_E1:
            begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
                w.emit   = 1'b1;
            end
            ST_SPARE: begin w.cond = C_ALWAYS;   w.target = ST_IDLE;  end
            default:  begin w.cond = C_ALWAYS;   w.target = ST_IDLE;  end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/edit_distance_engine_unit.sv -----
`timescale 1ns / 1ps

// Levenshtein edit distance engine (unit cost insert / delete / substitute).
// Input: a transaction is taken at a rising edge with start high and busy low.
//   kind 0 loads one target byte, kind 1 feeds one source byte and updates
//   the DP row, kind 2 ends the pair and emits the distance, kind 3 is dropped.
// Output: distance and too_long are valid for exactly one cycle while done
//   is high; the receiver cannot hold results off, so sample on done.
// Steps per transaction, from accept until busy falls:
//   target byte DISP0, T0, T1; source byte DISP0, DISP1, S0, S1, S2, then
//   one CELL step per target byte and SDONE (S1 ends it on an empty target);
//   end DISP0, DISP1, DISP2, E0, E1 (done rises in the cycle busy falls);
//   overflow leaves T0 or S0 for OVF; kind 3 ends at DROP. Source cost is set
//   by the DP cell loop: one cell per cycle through a single row memory port.
// Bytes beyond MAX_LEN of either string are dropped and set too_long.
// Reset clears lengths, the overflow flag, row entry zero and the step
//   counter; the target and row memories need no clearing since only
//   entries written within the current pair are ever read.
// Control is a microprogram in a 16-word table stepping a small datapath.
module edit_distance_engine_unit #(
    parameter int MAX_LEN = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ed_pkg::KIND_W-1:0] kind,
    input  logic [ed_pkg::SYM_W-1:0]  symbol,
    output logic                      done,
    output logic [ed_pkg::DIST_W-1:0] distance,
    output logic                      too_long
);
    import ed_pkg::*;

    ctrl_t   ctrl;
    status_t status;
    logic    accept;

    // Take the transaction only while the sequencer sits in its idle step
    assign accept = start & ~busy;

    ed_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    ed_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .kind     (kind),
        .symbol   (symbol),
        .ctrl     (ctrl),
        .status   (status),
        .distance (distance),
        .too_long (too_long),
        .done     (done)
    );

endmodule

// ----- rtl/core/ed_seq.sv -----
`timescale 1ns / 1ps

module ed_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  ed_pkg::status_t status,
    output ed_pkg::ctrl_t   ctrl,
    output logic            busy
);
    import ed_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             take;

    assign ctrl = ed_rom(upc_reg);
    assign busy = (upc_reg != ST_IDLE);

    always_comb
    begin
        unique case (ctrl.cond)
            C_ALWAYS:   take = 1'b1;
            C_NO_START: take = !start;
            C_KIND0:    take = status.kind0;
            C_KIND1:    take = status.kind1;
            C_KIND2:    take = status.kind2;
            C_TFULL:    take = status.tfull;
            C_SFULL:    take = status.sfull;
            C_TZERO:    take = status.tzero;
            C_J_MORE:   take = status.jmore;
            default:    take = 1'b1;
        endcase
        upc_next = take ? ctrl.target : upc_reg + UPC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= ST_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ----- rtl/core/ed_datapath.sv -----
`timescale 1ns / 1ps

module ed_datapath #(
    parameter int MAX_LEN = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [ed_pkg::KIND_W-1:0] kind,
    input  logic [ed_pkg::SYM_W-1:0]  symbol,
    input  ed_pkg::ctrl_t             ctrl,
    output ed_pkg::status_t           status,
    output logic [ed_pkg::DIST_W-1:0] distance,
    output logic                      too_long,
    output logic                      done
);
    import ed_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    // Row entries never exceed twice the longest string
    localparam int CW = $clog2(2 * MAX_LEN + 1);

    logic [SYM_W-1:0]  tgt_mem [MAX_LEN];
    logic [CW-1:0]     row_mem [MAX_LEN];

    logic [KIND_W-1:0] kind_reg;
    logic [SYM_W-1:0]  symbol_reg;
    logic [LW-1:0]     tlen_reg;
    logic [LW-1:0]     slen_reg;
    logic              ovf_reg;
    logic [CW-1:0]     row0_reg;
    logic [CW-1:0]     diag_reg;
    logic [CW-1:0]     left_reg;
    logic [LW-1:0]     j_reg;
    logic [CW-1:0]     rd_row_reg;
    logic [SYM_W-1:0]  rd_tgt_reg;
    logic [DIST_W-1:0] distance_reg;
    logic              done_reg;

    logic [LW-1:0]     tlen_inc;
    logic [LW-1:0]     tlen_m1;
    logic [LW-1:0]     slen_inc;
    logic [LW-1:0]     j_m1;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [CW-1:0]     wr_data;
    logic              row_we;
    logic [CW:0]       up_c;
    logic [CW:0]       left_c;
    logic [CW:0]       diag_c;
    logic [CW:0]       best_a;
    logic [CW:0]       best;
    logic [CW-1:0]     final_cost;
    logic [CW+DIST_W-1:0] final_wide;

    assign tlen_inc = tlen_reg + LW'(1);
    assign tlen_m1  = tlen_reg - LW'(1);
    assign slen_inc = slen_reg + LW'(1);
    assign j_m1     = j_reg - LW'(1);

    always_comb
    begin
        unique case (ctrl.rd_sel)
            RD_J:      rd_addr = j_m1[AW-1:0];
            RD_J_NEXT: rd_addr = j_reg[AW-1:0];
            RD_TLEN:   rd_addr = tlen_m1[AW-1:0];
            default:   rd_addr = '0;
        endcase
    end

    // One DP cell: min of deletion, insertion and substitution
    always_comb
    begin
        up_c   = {1'b0, rd_row_reg} + {{CW{1'b0}}, 1'b1};
        left_c = {1'b0, left_reg} + {{CW{1'b0}}, 1'b1};
        diag_c = {1'b0, diag_reg} + {{CW{1'b0}}, (rd_tgt_reg != symbol_reg)};
        best_a = (up_c < left_c) ? up_c : left_c;
        best   = (diag_c < best_a) ? diag_c : best_a;
    end

    always_comb
    begin
        row_we  = ctrl.ld_tgt | ctrl.cell_en;
        wr_addr = ctrl.cell_en ? j_m1[AW-1:0] : tlen_reg[AW-1:0];
        wr_data = ctrl.cell_en ? best[CW-1:0] : CW'(tlen_inc);
    end

    assign final_cost = (tlen_reg == '0) ? row0_reg : rd_row_reg;
    assign final_wide = {{DIST_W{1'b0}}, final_cost};

    always_comb
    begin
        status.kind0 = (kind_reg == KIND_TARGET);
        status.kind1 = (kind_reg == KIND_SOURCE);
        status.kind2 = (kind_reg == KIND_END);
        status.tfull = (tlen_reg == LW'(MAX_LEN));
        status.sfull = (slen_reg == LW'(MAX_LEN));
        status.tzero = (tlen_reg == '0);
        status.jmore = (j_reg != tlen_reg);
    end

    // Memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.ld_tgt)
        begin
            tgt_mem[tlen_reg[AW-1:0]] <= symbol_reg;
        end
        if (row_we)
        begin
            row_mem[wr_addr] <= wr_data;
        end
        rd_row_reg <= row_mem[rd_addr];
        rd_tgt_reg <= tgt_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind;
            symbol_reg <= symbol;
        end
        if (ctrl.src_init)
        begin
            diag_reg <= row0_reg;
            left_reg <= CW'(slen_inc);
            j_reg    <= LW'(1);
        end
        else if (ctrl.cell_en)
        begin
            diag_reg <= rd_row_reg;
            left_reg <= best[CW-1:0];
            j_reg    <= j_reg + LW'(1);
        end
        if (ctrl.emit)
        begin
            distance_reg <= final_wide[DIST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlen_reg <= '0;
            slen_reg <= '0;
            ovf_reg  <= 1'b0;
            row0_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.emit;
            if (ctrl.emit)
            begin
                tlen_reg <= '0;
                slen_reg <= '0;
                ovf_reg  <= 1'b0;
                row0_reg <= '0;
            end
            else
            begin
                if (ctrl.ld_tgt)
                begin
                    tlen_reg <= tlen_inc;
                end
                if (ctrl.src_init)
                begin
                    slen_reg <= slen_inc;
                    row0_reg <= CW'(slen_inc);
                end
                if (ctrl.set_ovf)
                begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    // too_long is sampled with the emitted distance, before the clear takes effect
    logic too_long_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            too_long_reg <= ovf_reg;
        end
    end

    assign distance = distance_reg;
    assign too_long = too_long_reg;
    assign done     = done_reg;

endmodule

// ----- rtl/core/ed_checker.sv -----
`timescale 1ns / 1ps

module ed_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // A result strobe lasts exactly one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for more than one cycle");

    // An accepted transaction always makes the engine busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // Results appear only once the engine is back in its idle step
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done asserted while busy");

    // Busy only rises after a start was seen
    assert property (@(posedge clk) disable iff (!rst_n) $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

endmodule

bind edit_distance_engine_unit ed_checker u_ed_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
